// ----- hw/rtl/fwhist_pkg.sv -----
// Shared types and constants for the fixed-width histogram engine.
package fwhist_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W    = 17;
	localparam int READ_BIN_W  = 8;
	localparam int RESULT_W    = 32;
	// Widest bin index and widest counter that the block supports.
	localparam int BIN_IDX_W   = 12;
	localparam int COUNT_EXT_W = 48;
	// Restoring divider: one quotient bit per step.
	localparam int DIV_STEPS   = SAMPLE_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);
	// Depth of the command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Item opcodes.
	localparam logic [1:0] OP_ACCUMULATE = 2'd0;
	localparam logic [1:0] OP_READ       = 2'd1;
	localparam logic [1:0] OP_CLEAR      = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] REG_MIN_VALUE = 1'b0;
	localparam logic [0:0] REG_BIN_WIDTH = 1'b1;

	typedef enum logic [1:0] {
		CMD_ACCUMULATE,
		CMD_READ,
		CMD_CLEAR
	} cmd_kind_t;

	// One classified command handed from the front part to the back part.
	typedef struct packed {
		cmd_kind_t              kind;
		logic [BIN_IDX_W-1:0]   bin;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIVIDE,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_SWEEP,
		B_IDLE,
		B_UPDATE,
		B_REPORT
	} back_state_t;

endpackage

// ----- hw/rtl/fixed_width_histogram.sv -----
// Top level of the fixed-width histogram engine.
// Usage:
// An item is taken at a clock edge where start is high and busy is low. Opcode 0 counts
// sample_value in bin (sample_value - min_value) / bin_width, clamped to the last bin,
// with samples below min_value going to bin 0. Opcode 1 reads bin read_bin, opcode 2
// clears all bins, opcode 3 is dropped. Configuration is written through cfg_write,
// cfg_index and cfg_data while the block is idle.
// A read returns one beat: result_strobe is high for exactly one cycle with bin_number and
// bin_count; the receiver cannot stall it. The strobe follows the accept edge through the
// front F_PUSH state, the command queue and the back B_IDLE and B_REPORT states.
// The front part pushes a read, clear or sample below min_value without dividing; any other
// sample first runs the bit-serial divider, which produces one quotient bit per cycle.
// The back part handles a sample or read through B_UPDATE or B_REPORT, and a clear by a sweep
// of the counter memory, one entry per cycle; a two-entry queue lets the front keep accepting
// during that sweep.
// After reset the counter memory is swept to zero, which keeps busy high until the sweep
// ends; configuration writes are taken during that time.
module fixed_width_histogram #(
	parameter int BIN_COUNT  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [fwhist_pkg::SAMPLE_W-1:0]    sample_value,
	input  logic [fwhist_pkg::READ_BIN_W-1:0]  read_bin,
	input  logic                               cfg_write,
	input  logic [0:0]                         cfg_index,
	input  logic [fwhist_pkg::SAMPLE_W-1:0]    cfg_data,
	output logic                               result_strobe,
	output logic [fwhist_pkg::READ_BIN_W-1:0]  bin_number,
	output logic [fwhist_pkg::RESULT_W-1:0]    bin_count
);
	import fwhist_pkg::*;

	logic [SAMPLE_W-1:0]  min_value_q;
	logic [SAMPLE_W-1:0]  bin_width_q;
	logic                 front_busy;
	logic                 init_busy;
	logic                 front_start;
	logic                 q_push, q_pop, q_full, q_empty;
	cmd_t                 q_push_cmd, q_head;

	assign busy        = front_busy || init_busy;
	assign front_start = start && !init_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q <= SAMPLE_W'(1);
			bin_width_q <= SAMPLE_W'(390);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MIN_VALUE: min_value_q <= cfg_data;
				REG_BIN_WIDTH: bin_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fwhist_front #(
		.BIN_COUNT(BIN_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (front_start),
		.opcode       (opcode),
		.sample_value (sample_value),
		.read_bin     (read_bin),
		.min_value    (min_value_q),
		.bin_width    (bin_width_q),
		.queue_full   (q_full),
		.busy         (front_busy),
		.push         (q_push),
		.push_cmd     (q_push_cmd)
	);

	fwhist_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	fwhist_back #(
		.BIN_COUNT  (BIN_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (q_empty),
		.head          (q_head),
		.pop           (q_pop),
		.init_busy     (init_busy),
		.result_strobe (result_strobe),
		.bin_number    (bin_number),
		.bin_count     (bin_count)
	);

`ifndef SYNTH
	// A result beat lasts exactly one cycle.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("result strobe held for more than one cycle");

	// The front part never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command queue overflow");

	// The back part never takes a beat from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// An accepted item with a valid opcode keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_ACCUMULATE || opcode == OP_READ ||
		 opcode == OP_CLEAR)) |=> busy)
		else $error("busy did not rise after an accepted item");
`endif

endmodule

// ----- hw/rtl/fwhist_front.sv -----
// Front part: accepts items, finds the bin of a sample with a serial divider, queues commands.
module fwhist_front #(
	parameter int BIN_COUNT = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [1:0]                         opcode,
	input  logic [fwhist_pkg::SAMPLE_W-1:0]    sample_value,
	input  logic [fwhist_pkg::READ_BIN_W-1:0]  read_bin,
	input  logic [fwhist_pkg::SAMPLE_W-1:0]    min_value,
	input  logic [fwhist_pkg::SAMPLE_W-1:0]    bin_width,
	input  logic                               queue_full,
	output logic                               busy,
	output logic                               push,
	output fwhist_pkg::cmd_t                   push_cmd
);
	import fwhist_pkg::*;

	localparam logic [SAMPLE_W-1:0] LAST_BIN = SAMPLE_W'(BIN_COUNT - 1);

	front_state_t          state_q, state_d;
	logic [STEP_W-1:0]     step_q;
	logic [SAMPLE_W-1:0]   rem_q, quo_q, div_q;
	cmd_t                  cmd_q;
	logic                  accept;
	logic                  below_min;
	logic                  last_step;
	logic [SAMPLE_W:0]     shifted, trial;
	logic                  fits;
	logic [SAMPLE_W-1:0]   rem_next, quo_next;
	logic [BIN_IDX_W-1:0]  bin_clamped;

	assign accept    = start && (state_q == F_IDLE);
	assign below_min = sample_value < min_value;
	assign last_step = step_q == STEP_W'(DIV_STEPS - 1);

	// One restoring division step: bring down the next dividend bit, try the subtract.
	always_comb begin
		shifted     = {rem_q, quo_q[SAMPLE_W-1]};
		trial       = shifted - {1'b0, div_q};
		fits        = shifted >= {1'b0, div_q};
		rem_next    = fits ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
		quo_next    = {quo_q[SAMPLE_W-2:0], fits};
		bin_clamped = (quo_next > LAST_BIN) ? BIN_IDX_W'(BIN_COUNT - 1)
		                                    : quo_next[BIN_IDX_W-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_ACCUMULATE: state_d = below_min ? F_PUSH : F_DIVIDE;
						OP_READ, OP_CLEAR: state_d = F_PUSH;
						default: state_d = F_IDLE;
					endcase
				end
			end
			F_DIVIDE: begin
				if (last_step) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!queue_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy     = state_q != F_IDLE;
		push     = (state_q == F_PUSH) && !queue_full;
		push_cmd = cmd_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_DIVIDE) step_q <= step_q + STEP_W'(1);
			else step_q <= '0;
		end
	end

	// Divider and command registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= '0;
			quo_q <= sample_value - min_value;
			div_q <= (bin_width == '0) ? SAMPLE_W'(1) : bin_width;
			case (opcode)
				OP_ACCUMULATE: cmd_q <= '{kind: CMD_ACCUMULATE, bin: '0};
				OP_READ:       cmd_q <= '{kind: CMD_READ, bin: BIN_IDX_W'(read_bin)};
				OP_CLEAR:      cmd_q <= '{kind: CMD_CLEAR, bin: '0};
				default:       cmd_q <= cmd_q;
			endcase
		end else if (state_q == F_DIVIDE) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			if (last_step) cmd_q.bin <= bin_clamped;
		end
	end

endmodule

// ----- hw/rtl/fwhist_queue.sv -----
// Short command queue between the front and back parts.
module fwhist_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fwhist_pkg::cmd_t  push_cmd,
	input  logic              pop,
	output fwhist_pkg::cmd_t  head,
	output logic              full,
	output logic              empty
);
	import fwhist_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign head  = entries_q[rd_ptr_q];
	assign full  = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + (PTR_W + 1)'(1);
			else if (pop && !push) count_q <= count_q - (PTR_W + 1)'(1);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- hw/rtl/fwhist_back.sv -----
// Back part: holds the bin counters and carries out increment, read and clear commands.
module fwhist_back #(
	parameter int BIN_COUNT  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               queue_empty,
	input  fwhist_pkg::cmd_t                   head,
	output logic                               pop,
	output logic                               init_busy,
	output logic                               result_strobe,
	output logic [fwhist_pkg::READ_BIN_W-1:0]  bin_number,
	output logic [fwhist_pkg::RESULT_W-1:0]    bin_count
);
	import fwhist_pkg::*;

	localparam int IDX_W = $clog2(BIN_COUNT);

	logic [COUNT_BITS-1:0]   mem [BIN_COUNT];
	back_state_t             state_q, state_d;
	logic [IDX_W-1:0]        sweep_q;
	logic                    init_q;
	logic [IDX_W-1:0]        addr_q;
	logic [READ_BIN_W-1:0]   report_bin_q;
	logic                    in_range_q;
	logic [COUNT_BITS-1:0]   rd_q;
	logic                    head_in_range;
	logic [IDX_W-1:0]        raddr;
	logic                    sweep_done;
	logic                    mem_we;
	logic [IDX_W-1:0]        waddr;
	logic [COUNT_BITS-1:0]   wdata;
	logic [COUNT_BITS-1:0]   count_inc;
	logic [COUNT_EXT_W-1:0]  count_ext;

	// Address decode for the command at the queue head, sweep end and saturating counter increment.
	always_comb begin
		head_in_range = {1'b0, head.bin} < (BIN_IDX_W + 1)'(BIN_COUNT);
		raddr         = head_in_range ? head.bin[IDX_W-1:0] : '0;
		sweep_done    = sweep_q == IDX_W'(BIN_COUNT - 1);
		count_inc     = (rd_q == '1) ? rd_q : rd_q + COUNT_BITS'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_SWEEP: begin
				if (sweep_done) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!queue_empty) begin
					unique case (head.kind)
						CMD_ACCUMULATE: state_d = B_UPDATE;
						CMD_READ:       state_d = B_REPORT;
						CMD_CLEAR:      state_d = B_SWEEP;
						default:        state_d = B_IDLE;
					endcase
				end
			end
			B_UPDATE: state_d = B_IDLE;
			B_REPORT: state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// Outputs and memory write port.
	always_comb begin
		pop           = (state_q == B_IDLE) && !queue_empty;
		init_busy     = init_q;
		mem_we        = (state_q == B_SWEEP) || (state_q == B_UPDATE);
		waddr         = (state_q == B_SWEEP) ? sweep_q : addr_q;
		wdata         = (state_q == B_SWEEP) ? '0 : count_inc;
		result_strobe = state_q == B_REPORT;
		bin_number    = report_bin_q;
		count_ext     = COUNT_EXT_W'(rd_q);
		if (!in_range_q) bin_count = '0;
		else if (|count_ext[COUNT_EXT_W-1:RESULT_W]) bin_count = '1;
		else bin_count = count_ext[RESULT_W-1:0];
	end

	// Control registers; reset starts a clearing sweep of the counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_SWEEP;
			sweep_q <= '0;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == B_SWEEP) begin
				sweep_q <= sweep_done ? '0 : sweep_q + IDX_W'(1);
				if (sweep_done) init_q <= 1'b0;
			end
		end
	end

	// Command payload captured when a beat leaves the queue.
	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q       <= raddr;
			report_bin_q <= head.bin[READ_BIN_W-1:0];
			in_range_q   <= head_in_range;
		end
	end

	// Counter memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

endmodule
